/* hdl/mqw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the message queue with wait lists.
// No dependencies; every other file of the block imports this package.
package mqw_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 16;
  localparam int unsigned MAX_TASKS_DEF   = 8;
  localparam int unsigned WORD_BITS_DEF   = 32;

  localparam int unsigned CAP_W  = 5;
  localparam int unsigned TASK_W = 3;
  localparam int unsigned XFER_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_TRY_SEND = 2'd0,
    MODE_TRY_RECV = 2'd1,
    MODE_BLK_SEND = 2'd2,
    MODE_BLK_RECV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FAILED  = 2'd1,
    ST_BLOCKED = 2'd2
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic [XFER_W-1:0]   send_word;
    logic [TASK_W-1:0]   caller_task;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [XFER_W-1:0]   recv_word;
    logic                woke_valid;
    logic [TASK_W-1:0]   woke_task;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

/* hdl/message_queue_with_waiters.sv */
`timescale 1ns / 1ps
// Message queue with receive and send wait lists. An accepted item is held in
// the input register, resolved combinationally when it fires, and its result is
// registered in the result register. Throughput: one item per cycle while
// the result is not stalled, set by the pointer update and the
// registered head read of the message store. Reset clears pointers, counts and
// valids and sets capacity to 16; store and wait-list contents are undefined.
module message_queue_with_waiters #(
  parameter int unsigned STORE_DEPTH = mqw_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MAX_TASKS   = mqw_pkg::MAX_TASKS_DEF,
  parameter int unsigned WORD_BITS   = mqw_pkg::WORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mqw_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mqw_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mqw_pkg::out_item_t         out_item_o
);
  import mqw_pkg::*;

  localparam int unsigned PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CNT_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH + 1) : 1;
  localparam int unsigned EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  function automatic logic [PTR_W-1:0] msg_adv(input logic [PTR_W-1:0] ptr,
                                               input logic [EW-1:0]    limit);
    logic [EW-1:0] n;
    n = EW'(ptr) + EW'(1);
    return (n >= limit) ? '0 : n[PTR_W-1:0];
  endfunction

  logic [CAP_W-1:0]     cap_q;
  logic [EW-1:0]        cap_x, eff_cap;

  logic                 in_valid_q, out_valid_q;
  in_item_t             in_item_q;
  out_item_t            out_item_q, out_d;
  logic                 fire, in_load;

  logic [WORD_BITS-1:0] store_q [STORE_DEPTH];
  logic [WORD_BITS-1:0] msg_rd_q, wr_word;
  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 msg_we, msg_full, msg_empty;

  ring_ctrl_t           recv_ctrl, send_ctrl;
  ring_stat_t           recv_stat, send_stat;
  logic [TASK_W-1:0]    recv_head, send_head;

  // capacity register: zero acts as one, clamp to the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cap_x = EW'(cap_q);
    if (cap_x == '0) begin
      eff_cap = EW'(1);
    end else if (cap_x > EW'(STORE_DEPTH)) begin
      eff_cap = EW'(STORE_DEPTH);
    end else begin
      eff_cap = cap_x;
    end
  end

  assign msg_full  = (EW'(count_q) >= eff_cap);
  assign msg_empty = (count_q == '0);
  assign wr_word   = WORD_BITS'(in_item_q.send_word);

  // handshake: the input register frees whenever the result register can load
  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign in_load     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    msg_we    = 1'b0;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    recv_ctrl = '0;
    send_ctrl = '0;
    out_d     = '{status: ST_DONE, recv_word: '0, woke_valid: 1'b0, woke_task: '0};
    if (fire) begin
      unique case (in_item_q.mode) inside
        MODE_TRY_SEND, MODE_BLK_SEND: begin
          if (!msg_full) begin
            msg_we           = 1'b1;
            tail_d           = msg_adv(tail_q, eff_cap);
            count_d          = count_q + CNT_W'(1);
            recv_ctrl.pop    = !recv_stat.empty;
            out_d.woke_valid = !recv_stat.empty;
            out_d.woke_task  = recv_stat.empty ? '0 : recv_head;
          end else if (in_item_q.mode == MODE_BLK_SEND) begin
            send_ctrl.push = 1'b1;
            out_d.status   = ST_BLOCKED;
          end else begin
            out_d.status = ST_FAILED;
          end
        end
        MODE_TRY_RECV, MODE_BLK_RECV: begin
          if (!msg_empty) begin
            head_d           = msg_adv(head_q, eff_cap);
            count_d          = count_q - CNT_W'(1);
            out_d.recv_word  = XFER_W'(msg_rd_q);
            send_ctrl.pop    = !send_stat.empty;
            out_d.woke_valid = !send_stat.empty;
            out_d.woke_task  = send_stat.empty ? '0 : send_head;
          end else if (in_item_q.mode == MODE_BLK_RECV) begin
            recv_ctrl.push = 1'b1;
            out_d.status   = ST_BLOCKED;
          end else begin
            out_d.status = ST_FAILED;
          end
        end
        default: begin
          out_d.status = ST_FAILED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
    end else begin
      in_valid_q  <= in_load || (in_valid_q && !fire);
      out_valid_q <= fire || (out_valid_q && out_stall_i);
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= out_d;
    end
  end

  // message store; msg_rd_q always holds the word at the head
  always_ff @(posedge clk_i) begin
    if (msg_we) begin
      store_q[tail_q] <= wr_word;
    end
    if (msg_we && (tail_q == head_d)) begin
      msg_rd_q <= wr_word;
    end else begin
      msg_rd_q <= store_q[head_d];
    end
  end

  mqw_wait_ring #(
    .MAX_TASKS (MAX_TASKS)
  ) u_recv_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (recv_ctrl),
    .task_i      (in_item_q.caller_task),
    .stat_o      (recv_stat),
    .head_task_o (recv_head)
  );

  mqw_wait_ring #(
    .MAX_TASKS (MAX_TASKS)
  ) u_send_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (send_ctrl),
    .task_i      (in_item_q.caller_task),
    .stat_o      (send_stat),
    .head_task_o (send_head)
  );

endmodule

/* hdl/mqw_wait_ring.sv */
`timescale 1ns / 1ps
// Ring of waiting task numbers with a registered head read.
// Depends on mqw_pkg.
module mqw_wait_ring #(
  parameter int unsigned MAX_TASKS = mqw_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mqw_pkg::ring_ctrl_t         ctrl_i,
  input  logic [mqw_pkg::TASK_W-1:0]  task_i,
  output mqw_pkg::ring_stat_t         stat_o,
  output logic [mqw_pkg::TASK_W-1:0]  head_task_o
);
  import mqw_pkg::*;

  localparam int unsigned PTR_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
  localparam logic [PTR_W:0]   WRAP_AT  = (PTR_W + 1)'(MAX_TASKS);

  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] ptr);
    logic [PTR_W:0] n;
    n = {1'b0, ptr} + (PTR_W + 1)'(1);
    return (n >= WRAP_AT) ? '0 : n[PTR_W-1:0];
  endfunction

  logic [TASK_W-1:0] slot_q [MAX_TASKS];
  logic [TASK_W-1:0] rd_q;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q >= FULL_CNT);
  assign head_task_o  = rd_q;

  // push to a full ring is dropped
  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && !stat_o.empty;

  always_comb begin
    head_d  = do_pop ? ring_adv(head_q) : head_q;
    tail_d  = do_push ? ring_adv(tail_q) : tail_q;
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // keep rd_q equal to the entry at the next head; forward a same-cycle write
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[tail_q] <= task_i;
    end
    if (do_push && (tail_q == head_d)) begin
      rd_q <= task_i;
    end else begin
      rd_q <= slot_q[head_d];
    end
  end

endmodule

/* hdl/mqw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the message queue with wait lists, and their binding.
// Depends on mqw_pkg and message_queue_with_waiters.
module mqw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mqw_pkg::out_item_t out_item_o
);
  import mqw_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input side only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_DONE)
      |-> (out_item_o.recv_word == '0) && !out_item_o.woke_valid)
    else $error("failed or blocked item carries data or a wake");

  a_woke_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.woke_valid |-> (out_item_o.woke_task == '0))
    else $error("woken task set without a wake");

endmodule

bind message_queue_with_waiters mqw_checker u_mqw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* dv/message_queue_with_waiters_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the message queue with receive and send wait lists.
// Depends on mqw_pkg and message_queue_with_waiters; predicts each result in-line.
module message_queue_with_waiters_tb;
  import mqw_pkg::*;

  localparam int unsigned DEPTH        = STORE_DEPTH_DEF;
  localparam int unsigned TASKS        = MAX_TASKS_DEF;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          RX_LIST      = 0;
  localparam int          TX_LIST      = 1;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;

  int snd_idle_pct  = 22;
  int rcv_stall_pct = 65;
  int hold_cycles   = 0;
  int mismatches    = 0;
  int n_results     = 0;

  // Shadow of the mailbox state
  logic [XFER_W-1:0] slot_mem [DEPTH];
  bit                slot_written [DEPTH];
  int unsigned       rd_ptr  = 0;
  int unsigned       wr_ptr  = 0;
  int unsigned       msg_cnt = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  logic [TASK_W-1:0] waiter_slot [2][TASKS];
  int unsigned       waiter_head [2] = '{0, 0};
  int unsigned       waiter_tail [2] = '{0, 0};
  int unsigned       waiter_cnt  [2] = '{0, 0};

  out_item_t pending_results [$];

  always #2 clk_i = ~clk_i;

  message_queue_with_waiters u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  function automatic int unsigned next_index(int unsigned idx, int unsigned limit);
    return (idx + 1 >= limit) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned active_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return 32'(cap_reg);
  endfunction

  function automatic void waiter_enqueue(int list, logic [TASK_W-1:0] tid);
    // drop silently when the list is full
    if (waiter_cnt[list] >= TASKS) return;
    waiter_slot[list][waiter_tail[list] % TASKS] = tid;
    waiter_tail[list] = next_index(waiter_tail[list], TASKS);
    waiter_cnt[list]++;
  endfunction

  function automatic bit waiter_release(int list, output logic [TASK_W-1:0] tid);
    tid = '0;
    if (waiter_cnt[list] == 0) return 1'b0;
    tid = waiter_slot[list][waiter_head[list] % TASKS];
    waiter_head[list] = next_index(waiter_head[list], TASKS);
    waiter_cnt[list]--;
    return 1'b1;
  endfunction

  function automatic out_item_t resolve_request(in_item_t req);
    out_item_t         res;
    bit                is_recv;
    bit                blocking;
    int unsigned       cap;
    logic [TASK_W-1:0] tid;
    res      = '0;
    is_recv  = (req.mode == MODE_TRY_RECV) || (req.mode == MODE_BLK_RECV);
    blocking = (req.mode == MODE_BLK_SEND) || (req.mode == MODE_BLK_RECV);
    cap      = active_capacity();
    res.status = ST_DONE;
    if (!is_recv) begin
      if (msg_cnt < cap) begin
        slot_mem[wr_ptr % DEPTH]     = req.send_word;
        slot_written[wr_ptr % DEPTH] = 1'b1;
        wr_ptr = next_index(wr_ptr, cap);
        msg_cnt++;
        if (waiter_release(RX_LIST, tid)) begin
          res.woke_valid = 1'b1;
          res.woke_task  = tid;
        end
      end else if (blocking) begin
        waiter_enqueue(TX_LIST, req.caller_task);
        res.status = ST_BLOCKED;
      end else begin
        res.status = ST_FAILED;
      end
    end else begin
      if (msg_cnt != 0) begin
        res.recv_word = slot_mem[rd_ptr % DEPTH];
        rd_ptr = next_index(rd_ptr, cap);
        msg_cnt--;
        if (waiter_release(TX_LIST, tid)) begin
          res.woke_valid = 1'b1;
          res.woke_task  = tid;
        end
      end else if (blocking) begin
        waiter_enqueue(RX_LIST, req.caller_task);
        res.status = ST_BLOCKED;
      end else begin
        res.status = ST_FAILED;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [XFER_W-1:0] got, logic [XFER_W-1:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got, want);
    mismatches++;
  endtask

  // Track config writes, predict accepted items, check accepted results
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("with nothing pending", out_item.recv_word, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", XFER_W'(out_item.status), XFER_W'(want.status));
          if (out_item.recv_word !== want.recv_word)
            report_mismatch("recv_word", out_item.recv_word, want.recv_word);
          if (out_item.woke_valid !== want.woke_valid)
            report_mismatch("woke_valid", XFER_W'(out_item.woke_valid),
                            XFER_W'(want.woke_valid));
          if (out_item.woke_task !== want.woke_task)
            report_mismatch("woke_task", XFER_W'(out_item.woke_task),
                            XFER_W'(want.woke_task));
        end
        n_results++;
      end
      if (in_valid && !in_stall) pending_results.push_back(resolve_request(in_item));
    end
  end

  // Receiver stall: long hold-off first, otherwise random
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the edge that accepts the item
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic request(mode_e m, logic [XFER_W-1:0] w, logic [TASK_W-1:0] tid);
    in_item_t it;
    it.mode        = m;
    it.send_word   = w;
    it.caller_task = tid;
    @(negedge clk_i);
    send_item(it);
  endtask

  task automatic random_request(int send_pct);
    bit                is_send;
    bit                blk;
    logic [XFER_W-1:0] w;
    in_item_t          it;
    // decide at the falling edge, once the last accepted item is predicted
    @(negedge clk_i);
    is_send = ($urandom_range(99) < send_pct);
    blk     = 1'($urandom_range(1));
    // never read a slot that has not been written yet
    if (!is_send && msg_cnt != 0 && !slot_written[rd_ptr % DEPTH]) is_send = 1'b1;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    it.mode        = is_send ? (blk ? MODE_BLK_SEND : MODE_TRY_SEND)
                             : (blk ? MODE_BLK_RECV : MODE_TRY_RECV);
    it.send_word   = w;
    it.caller_task = TASK_W'($urandom_range(TASKS - 1));
    send_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_try_and_wake();
    request(MODE_TRY_RECV, '0, 3'd0);
    request(MODE_BLK_RECV, '0, 3'd5);
    request(MODE_BLK_RECV, '0, 3'd0);
    request(MODE_TRY_SEND, 32'hFFFF_FFFF, 3'd7);
    request(MODE_BLK_SEND, 32'h0000_0000, 3'd7);
    request(MODE_TRY_RECV, '0, 3'd7);
    request(MODE_BLK_RECV, '1, 3'd7);
  endtask

  // Zero in the register behaves as one slot
  task automatic test_zero_capacity();
    write_capacity('0);
    request(MODE_TRY_SEND, 32'hA5A5_A5A5, 3'd7);
    request(MODE_TRY_SEND, 32'h5A5A_5A5A, 3'd0);
    request(MODE_BLK_SEND, 32'h1234_5678, 3'd7);
    request(MODE_BLK_SEND, 32'h8765_4321, 3'd3);
    request(MODE_TRY_RECV, '0, 3'd0);
    request(MODE_BLK_RECV, '0, 3'd2);
  endtask

  // Fill the send wait list past its size, then widen capacity with a message held
  task automatic test_wait_list_overflow();
    request(MODE_TRY_SEND, 32'h0000_0001, 3'd0);
    for (int i = 0; i < TASKS; i++) request(MODE_BLK_SEND, $urandom, i[TASK_W-1:0]);
    request(MODE_BLK_SEND, 32'hDEAD_BEEF, 3'd6);
    write_capacity(5'd31);
    request(MODE_TRY_SEND, 32'h5555_AAAA, 3'd1);
    request(MODE_TRY_RECV, '0, 3'd1);
    request(MODE_BLK_RECV, '0, 3'd4);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap_pick;
    for (int s = 0; s < 3; s++) begin
      case (s)
        0:       begin snd_idle_pct = 22; rcv_stall_pct = 65; end
        1:       begin snd_idle_pct = 65; rcv_stall_pct = 22; end
        default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0:       cap_pick = 5'd1;
          1:       cap_pick = (s == 1) ? 5'd31 : 5'd16;
          2:       cap_pick = CAP_W'($urandom_range(31));
          default: cap_pick = CAP_W'($urandom_range(5, 2));
        endcase
        write_capacity(cap_pick);
        // sweep the send/receive mix so both full and empty are reached
        for (int b = 0; b < 3; b++) repeat (36) random_request(25 + 25 * b);
      end
    end
  endtask

  task automatic test_output_backpressure();
    write_capacity(5'd16);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_cycles   = 300;
    repeat (40) random_request(60);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_try_and_wake();
    test_zero_capacity();
    test_wait_list_overflow();
    write_capacity(5'd16);
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hdl/mqw_pkg.sv
hdl/mqw_wait_ring.sv
hdl/message_queue_with_waiters.sv
hdl/mqw_checker.sv
dv/message_queue_with_waiters_tb.sv
